@@ rtl/clfr_pkg.sv @@
`default_nettype none

package clfr_pkg;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int OUT_ADDR_W = 10;
  localparam int LEN_W      = 15;

  // Line framing characters and limits
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0d;
  localparam logic [LEN_W-1:0]  LEN_MAX = 15'h7fff;

  // One result: a ring write descriptor plus the new rear position
  typedef struct packed {
    logic                  write_enable;
    logic [OUT_ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0]     write_data;
    logic                  line_committed;
    logic [OUT_ADDR_W-1:0] rear_position;
  } clfr_res_t;

endpackage

`default_nettype wire

@@ rtl/clfr_if.sv @@
`default_nettype none

// Byte request channel
interface clfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [clfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Ring write result channel
interface clfr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           write_enable;
  logic [clfr_pkg::OUT_ADDR_W-1:0] write_address;
  logic [clfr_pkg::BYTE_W-1:0]     write_data;
  logic                           line_committed;
  logic [clfr_pkg::OUT_ADDR_W-1:0] rear_position;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output line_committed, output rear_position,
                  input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_data, input line_committed, input rear_position,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/clfr_core.sv @@
`default_nettype none

// Framer state and per-byte update. State advances on each accepted byte;
// the result is handed to the output stage in the same cycle.
module clfr_core #(
  parameter int RING_SIZE = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        line_mode,
  input  wire logic                        acc,
  input  wire logic [clfr_pkg::BYTE_W-1:0] rx_byte,
  output clfr_pkg::clfr_res_t              res
);
  import clfr_pkg::*;

  localparam int AW = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;
  localparam int WW = (AW > OUT_ADDR_W) ? AW : OUT_ADDR_W;
  localparam logic [AW:0]   RING_S   = (AW+1)'(RING_SIZE);
  localparam logic [AW-1:0] RING_TOP = AW'(RING_SIZE - 1);

  // rear position, pending CR, line length and its value modulo ring size
  logic [AW-1:0]    rear_r, rear_nxt;
  logic             crp_r, crp_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [AW-1:0]    lmod_r, lmod_nxt;

  logic             len_sat;
  logic [LEN_W-1:0] len_inc;
  logic [AW-1:0]    lmod_inc;
  logic [AW:0]      sum_commit, sum_stage, sum_raw;
  logic [AW-1:0]    pos_commit, pos_stage, pos_raw;
  logic [AW-1:0]    addr;
  logic [WW-1:0]    addr_wide, rear_wide;

  // Saturating length, with its ring-wrapped shadow
  assign len_sat  = (len_r == LEN_MAX);
  assign len_inc  = len_sat ? len_r : len_r + 1'b1;
  assign lmod_inc = len_sat ? lmod_r : ((lmod_r == RING_TOP) ? '0 : lmod_r + 1'b1);

  // Candidate positions; each sum stays below twice the ring size
  assign sum_commit = {1'b0, rear_r} + {1'b0, lmod_r} + 1'b1;
  assign sum_stage  = {1'b0, rear_r} + {1'b0, lmod_inc};
  assign sum_raw    = {1'b0, rear_r} + 1'b1;
  assign pos_commit = (sum_commit >= RING_S) ? AW'(sum_commit - RING_S) : AW'(sum_commit);
  assign pos_stage  = (sum_stage  >= RING_S) ? AW'(sum_stage  - RING_S) : AW'(sum_stage);
  assign pos_raw    = (sum_raw    >= RING_S) ? AW'(sum_raw    - RING_S) : AW'(sum_raw);

  // Next state and result for the byte at the input
  always_comb begin
    rear_nxt = rear_r;
    crp_nxt  = crp_r;
    len_nxt  = len_r;
    lmod_nxt = lmod_r;
    addr     = '0;
    res      = '0;
    if (line_mode) begin
      if (crp_r) begin
        if (rx_byte == BYTE_LF && len_r != '0) begin
          rear_nxt           = pos_commit;
          addr               = pos_commit;
          res.write_enable   = 1'b1;
          res.line_committed = 1'b1;
        end
        len_nxt  = '0;
        lmod_nxt = '0;
        crp_nxt  = (rx_byte == BYTE_CR);
      end else if (rx_byte == BYTE_CR) begin
        crp_nxt = 1'b1;
      end else begin
        len_nxt          = len_inc;
        lmod_nxt         = lmod_inc;
        addr             = pos_stage;
        res.write_enable = 1'b1;
        res.write_data   = rx_byte;
      end
    end else begin
      rear_nxt         = pos_raw;
      addr             = pos_raw;
      res.write_enable = 1'b1;
      res.write_data   = rx_byte;
    end
    addr_wide         = WW'(addr);
    rear_wide         = WW'(rear_nxt);
    res.write_address = addr_wide[OUT_ADDR_W-1:0];
    res.rear_position = rear_wide[OUT_ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rear_r <= '0;
      crp_r  <= 1'b0;
      len_r  <= '0;
      lmod_r <= '0;
    end else if (acc) begin
      rear_r <= rear_nxt;
      crp_r  <= crp_nxt;
      len_r  <= len_nxt;
      lmod_r <= lmod_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/clfr_skid.sv @@
`default_nettype none

// Output register with one skid entry: a new request is taken while
// a finished result waits downstream.
module clfr_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  clfr_pkg::clfr_res_t      in_res,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output clfr_pkg::clfr_res_t      out_res
);
  import clfr_pkg::*;

  logic      out_v_r, out_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  clfr_res_t out_r, out_nxt;
  clfr_res_t skid_r, skid_nxt;
  logic      push, pop;

  assign in_ready  = !skid_v_r;
  assign push      = in_valid && !skid_v_r;
  assign pop       = out_v_r && out_ready;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  // Fill the output register first, spill into the skid entry on a stall
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (pop || !out_v_r) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        if (push) begin
          out_nxt = in_res;
        end
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = in_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/crlf_line_framer_ring_core.sv @@
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in_ch   | sink      | valid / ready        | rx_byte[7:0]
//  out_ch  | source    | valid / ready        | write_enable, write_address[9:0],
//          |           |                      | write_data[7:0], line_committed,
//          |           |                      | rear_position[9:0]
//  cfg     | sink      | cfg_we (no stall)    | cfg_wdata = line_mode
//
//  One byte per cycle unless the output stalls; each result is registered in the
//  output register, or in the skid entry on a stall. The per-byte state update (rear,
//  pending CR, line length) is a single compare/add pass, which sets the state loop.
//  rst_n is synchronous: state, mode and both output entries clear at once.
//  On an output stall one more request is held in the skid entry, then
//  in_ch.ready drops until the output drains.
`default_nettype none

module crlf_line_framer_ring_core #(
  parameter int RING_SIZE = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  clfr_in_if.sink         in_ch,
  clfr_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata
);
  import clfr_pkg::*;

  logic      line_mode_r;
  logic      acc;
  logic      skid_ready;
  clfr_res_t step_res;
  clfr_res_t out_res;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r <= 1'b0;
    end else if (cfg_we) begin
      line_mode_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = skid_ready;
  assign acc         = in_ch.valid && skid_ready;

  clfr_core #(
    .RING_SIZE (RING_SIZE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .line_mode (line_mode_r),
    .acc       (acc),
    .rx_byte   (in_ch.rx_byte),
    .res       (step_res)
  );

  clfr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (skid_ready),
    .in_res    (step_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.write_enable   = out_res.write_enable;
  assign out_ch.write_address  = out_res.write_address;
  assign out_ch.write_data     = out_res.write_data;
  assign out_ch.line_committed = out_res.line_committed;
  assign out_ch.rear_position  = out_res.rear_position;

endmodule

`default_nettype wire

@@ rtl/clfr_check.sv @@
`default_nettype none

module clfr_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       write_enable,
  input wire logic [9:0] write_address,
  input wire logic [7:0] write_data,
  input wire logic       line_committed,
  input wire logic [9:0] rear_position
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_address) &&
      $stable(write_data) && $stable(rear_position))
    else $error("result changed while stalled");

  // A commit writes a zero terminator at the new rear position
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_committed |-> write_enable && write_data == 8'h00 &&
      write_address == rear_position)
    else $error("commit result malformed");

  // No write means zero address and data
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_enable |-> write_address == 10'd0 && write_data == 8'h00)
    else $error("idle write fields not zero");

  // Nothing is shown right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind crlf_line_framer_ring_core clfr_check u_clfr_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .write_enable   (out_ch.write_enable),
  .write_address  (out_ch.write_address),
  .write_data     (out_ch.write_data),
  .line_committed (out_ch.line_committed),
  .rear_position  (out_ch.rear_position)
);

`default_nettype wire
